// ===== rtl/core/pfv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the portable file name validator: byte codes, UTF-8 classes and helpers.
package pfv_pkg;

  localparam int unsigned CountBits  = 9;
  localparam int unsigned StemBits   = 3;
  localparam int unsigned LeadDepth  = 4;

  localparam logic [CountBits-1:0] COUNT_LIMIT    = 9'd256;
  localparam logic [CountBits-1:0] MAX_NAME_BYTES = 9'd255;
  localparam logic [StemBits-1:0]  STEM_LIMIT     = 3'd5;

  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [23:0] W_CON = "con";
  localparam logic [23:0] W_PRN = "prn";
  localparam logic [23:0] W_AUX = "aux";
  localparam logic [23:0] W_NUL = "nul";
  localparam logic [23:0] W_COM = "com";
  localparam logic [23:0] W_LPT = "lpt";

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  localparam logic [20:0] CP_MIN2     = 21'h00080;
  localparam logic [20:0] CP_MIN3     = 21'h00800;
  localparam logic [20:0] CP_MIN4     = 21'h10000;
  localparam logic [20:0] CP_MAX      = 21'h10ffff;
  localparam logic [20:0] CP_SURR_LO  = 21'h0d800;
  localparam logic [20:0] CP_SURR_HI  = 21'h0dfff;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_class_t;

  function automatic logic [7:0] fold_lc(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] b);
    logic f;
    f = (b < CH_SPACE) || (b == CH_DEL);
    if (b inside {CH_SLASH, CH_BSLASH, CH_COLON, CH_STAR, CH_QMARK,
                  CH_QUOTE, CH_LT, CH_GT, CH_PIPE}) begin
      f = 1'b1;
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/portable_filename_validator_unit.sv =====
`timescale 1ns / 1ps
// Portable file name validator: one name byte per beat, one verdict per name.
// Path: the last byte's beat is held in the input register, and the verdict on it is
// then written to the verdict register, from which it is handed on.
// Throughput: one byte per cycle while no final beat meets a stalled verdict; the
// input and verdict registers let a new byte enter while an earlier verdict waits.
// Reset (rst, synchronous): clears control and per-name counters; the first-byte
// registers are not reset and are written before they are read; no clearing pass.
module portable_filename_validator_unit
  import pfv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] name_byte,
  input  logic       last_byte,
  input  logic       empty_name,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic       name_ok
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_empty;

  // per-name state
  logic [CountBits-1:0] byte_count;
  logic [7:0]           leading_bytes [LeadDepth];
  logic [StemBits-1:0]  stem_length;
  logic                 dot_found;
  logic [1:0]           pending_continuations;
  logic [20:0]          partial_codepoint;
  seq_class_t           sequence_class;
  logic                 rule_broken;

  logic [CountBits-1:0] byte_count_next;
  logic [7:0]           lead_next [LeadDepth];
  logic [StemBits-1:0]  stem_length_next;
  logic                 dot_found_next;
  logic [1:0]           pending_next;
  logic [20:0]          codepoint_next;
  seq_class_t           class_next;
  logic                 broken_next;

  logic        s1_result;
  logic        s1_fire;
  logic        ok;
  logic [20:0] cp_shift;
  logic [20:0] cp_min;
  logic [23:0] stem3;
  logic        reserved;

  assign s1_result  = s1_last || s1_empty;
  assign byte_stall = s1_valid && s1_result && verdict_valid && verdict_stall;
  assign s1_fire    = s1_valid && !byte_stall;

  always_comb begin
    byte_count_next = (byte_count < COUNT_LIMIT) ? byte_count + 9'd1 : byte_count;
    for (int i = 0; i < LeadDepth; i++) begin
      lead_next[i] = (byte_count == CountBits'(i)) ? s1_byte : leading_bytes[i];
    end
    dot_found_next   = dot_found;
    stem_length_next = stem_length;
    if (!dot_found) begin
      if (s1_byte == CH_DOT) begin
        dot_found_next = 1'b1;
      end else if (stem_length < STEM_LIMIT) begin
        stem_length_next = stem_length + 3'd1;
      end
    end
  end

  // UTF-8 decode step
  always_comb begin
    pending_next   = pending_continuations;
    class_next     = sequence_class;
    codepoint_next = partial_codepoint;
    broken_next    = rule_broken || is_forbidden(s1_byte);
    cp_shift       = {partial_codepoint[14:0], s1_byte[5:0]};
    case (sequence_class)
      SEQ_TWO:   cp_min = CP_MIN2;
      SEQ_THREE: cp_min = CP_MIN3;
      default:   cp_min = CP_MIN4;
    endcase
    if (pending_continuations != 2'd0) begin
      if (s1_byte[7:6] != 2'b10) begin
        broken_next    = 1'b1;
        pending_next   = 2'd0;
        class_next     = SEQ_NONE;
        codepoint_next = '0;
      end else begin
        pending_next = pending_continuations - 2'd1;
        if (pending_continuations == 2'd1) begin
          if (cp_shift < cp_min || cp_shift > CP_MAX ||
              (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI)) begin
            broken_next = 1'b1;
          end
          class_next     = SEQ_NONE;
          codepoint_next = '0;
        end else begin
          codepoint_next = cp_shift;
        end
      end
    end else if (s1_byte[7]) begin
      if (s1_byte >= LEAD2_LO && s1_byte <= LEAD2_HI) begin
        pending_next   = 2'd1;
        class_next     = SEQ_TWO;
        codepoint_next = {16'd0, s1_byte[4:0]};
      end else if (s1_byte >= LEAD3_LO && s1_byte <= LEAD3_HI) begin
        pending_next   = 2'd2;
        class_next     = SEQ_THREE;
        codepoint_next = {17'd0, s1_byte[3:0]};
      end else if (s1_byte >= LEAD4_LO && s1_byte <= LEAD4_HI) begin
        pending_next   = 2'd3;
        class_next     = SEQ_FOUR;
        codepoint_next = {18'd0, s1_byte[2:0]};
      end else begin
        broken_next = 1'b1;
      end
    end
  end

  // verdict on the updated state
  always_comb begin
    stem3    = {fold_lc(lead_next[0]), fold_lc(lead_next[1]), fold_lc(lead_next[2])};
    reserved = 1'b0;
    if (stem_length_next == 3'd3) begin
      reserved = (stem3 == W_CON) || (stem3 == W_PRN) ||
                 (stem3 == W_AUX) || (stem3 == W_NUL);
    end else if (stem_length_next == 3'd4) begin
      reserved = ((stem3 == W_COM) || (stem3 == W_LPT)) &&
                 lead_next[3] >= CH_ONE && lead_next[3] <= CH_NINE;
    end
    ok = !broken_next && pending_next == 2'd0 &&
         byte_count_next <= MAX_NAME_BYTES &&
         s1_byte != CH_DOT && s1_byte != CH_SPACE &&
         !(byte_count_next == 9'd1 && lead_next[0] == CH_DOT) &&
         !(byte_count_next == 9'd2 && lead_next[0] == CH_DOT && lead_next[1] == CH_DOT) &&
         !reserved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_byte  <= name_byte;
      s1_last  <= last_byte;
      s1_empty <= empty_name;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count            <= '0;
      stem_length           <= '0;
      dot_found             <= 1'b0;
      pending_continuations <= '0;
      partial_codepoint     <= '0;
      sequence_class        <= SEQ_NONE;
      rule_broken           <= 1'b0;
    end else if (s1_fire) begin
      if (s1_result) begin
        byte_count            <= '0;
        stem_length           <= '0;
        dot_found             <= 1'b0;
        pending_continuations <= '0;
        partial_codepoint     <= '0;
        sequence_class        <= SEQ_NONE;
        rule_broken           <= 1'b0;
      end else begin
        byte_count            <= byte_count_next;
        stem_length           <= stem_length_next;
        dot_found             <= dot_found_next;
        pending_continuations <= pending_next;
        partial_codepoint     <= codepoint_next;
        sequence_class        <= class_next;
        rule_broken           <= broken_next;
      end
    end
  end

  // first bytes of the name; unwritten entries are never read
  always_ff @(posedge clk) begin
    if (s1_fire && !s1_empty) begin
      for (int i = 0; i < LeadDepth; i++) begin
        leading_bytes[i] <= lead_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      name_ok <= ok && !s1_empty;
    end
  end

  a_empty_rejects: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_empty) |=> (verdict_valid && !name_ok))
    else $error("empty name beat did not give a reject verdict");

  a_clear_after_name: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_result) |=>
      (byte_count == '0 && pending_continuations == 2'd0 && !rule_broken && !dot_found))
    else $error("per-name state not cleared after verdict");

  a_seq_open: assert property (@(posedge clk) disable iff (rst)
    (pending_continuations != 2'd0) |-> (sequence_class != SEQ_NONE))
    else $error("continuations due with no open sequence");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && verdict_valid && verdict_stall))
    else $error("input stalled without a blocked verdict");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_result) |=> (byte_count <= COUNT_LIMIT && byte_count != '0))
    else $error("byte count out of range after a byte");

endmodule
